[rtl/core/task_heartbeat_supervisor_defines.svh]
// Assertion macros for the heartbeat supervisor
`ifndef TASK_HEARTBEAT_SUPERVISOR_DEFINES_SVH
`define TASK_HEARTBEAT_SUPERVISOR_DEFINES_SVH

// Check consequent in the same cycle as the antecedent
`define THS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("heartbeat supervisor assertion failed");

// Check consequent in the cycle after the antecedent
`define THS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("heartbeat supervisor assertion failed");

`endif

[rtl/core/ths_pkg.sv]
// Types, constants and helpers of the heartbeat supervisor
package ths_pkg;

   localparam int TASK_SLOTS = 16;
   localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CNT_W      = $clog2(TASK_SLOTS + 1);
   localparam int MASK_W     = 16;
   localparam int TIME_W     = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_SILENCE  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_WARMUP   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_REQUIRED = 2'd2;

   localparam logic [TIME_W-1:0] SILENCE_RST  = 32'd20000;
   localparam logic [TIME_W-1:0] WARMUP_RST   = 32'd15000;
   localparam logic [MASK_W-1:0] REQUIRED_RST = 16'hFFFF;
   localparam logic [TIME_W-1:0] TIME_MAX     = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      OP_START,
      OP_REGISTER,
      OP_HEARTBEAT,
      OP_CHECK
   } opcode_type;

   typedef enum logic [2:0] {
      STAT_DONE,
      STAT_IGNORED,
      STAT_WAITING,
      STAT_FED,
      STAT_STALE
   } status_type;

   typedef struct packed {
      opcode_type        opcode;
      logic [3:0]        task_id;
      logic              handle_present;
      logic [TIME_W-1:0] time_ms;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic              feed;
      logic              armed;
      logic              just_armed;
      logic              warmup_done;
      logic [TIME_W-1:0] max_gap_ms;
      logic [TIME_W-1:0] remaining_ms;
      logic [MASK_W-1:0] overdue_mask;
      logic [MASK_W-1:0] warn_mask;
      logic [MASK_W-1:0] waiting_mask;
   } rsp_type;

   function automatic logic slot_required(logic [MASK_W-1:0] mask, logic [SLOT_W-1:0] slot);
      int idx;
      idx = int'(slot);
      return (idx < MASK_W) ? mask[idx[3:0]] : 1'b0;
   endfunction

   function automatic logic [MASK_W-1:0] slot_bit(logic [SLOT_W-1:0] slot);
      int idx;
      idx = int'(slot);
      return (idx < MASK_W) ? (MASK_W'(1) << idx[3:0]) : '0;
   endfunction

endpackage

[rtl/core/task_heartbeat_supervisor.sv]
// Heartbeat supervisor: slot table in a synchronous RAM, check by slot scan
//
// Usage:
//  - Items enter on req_data when start is high and busy is low.
//  - One result per item on rsp_data, marked by a one-cycle rsp_valid strobe;
//    the receiver cannot stall, so results are never held.
//  - Start, register and heartbeat items: the result strobes in the next
//    cycle and busy stays low, so one such item can be taken every cycle.
//  - A check reads the last-seen RAM one slot per cycle through its single
//    read port, then decides in the finish state: busy is high throughout
//    and the result strobes in the cycle busy falls.
//  - csr_we writes the silence limit (index 0), the warmup (1) or the
//    required mask (2) at once; other indexes are dropped. Write only while idle.
//  - Synchronous reset restores the register defaults, disarms, clears the
//    start time, marks every slot unregistered and never seen. No clearing
//    pass: one valid bit per slot stands in for the RAM contents.
`include "task_heartbeat_supervisor_defines.svh"

module task_heartbeat_supervisor
   import ths_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type                  state_ff;
   logic [TIME_W-1:0]          silence_ff;
   logic [TIME_W-1:0]          warmup_ff;
   logic [MASK_W-1:0]          required_ff;
   logic                       armed_ff;
   logic [TIME_W-1:0]          start_ff;
   logic [TASK_SLOTS-1:0]      reg_ff;
   logic [TASK_SLOTS-1:0]      valid_ff;

   logic [TIME_W-1:0]          now_ff;
   logic [TIME_W-1:0]          elapsed_ff;
   logic [TIME_W-1:0]          silence_p1_ff;
   logic [TIME_W-1:0]          three_q_ff;
   logic                       warm_ff;
   logic [CNT_W-1:0]           issue_cnt_ff;
   logic                       proc_vld_ff;
   logic [SLOT_W-1:0]          proc_idx_ff;
   logic [TIME_W-1:0]          maxgap_ff;
   logic [MASK_W-1:0]          never_ff;
   logic [MASK_W-1:0]          waitm_ff;
   logic [MASK_W-1:0]          warn_ff;
   logic [MASK_W-1:0]          stale_ff;
   rsp_type                    rsp_ff;
   logic                       rsp_valid_ff;
   rsp_type                    rsp_in;
   logic                       rsp_valid_in;

   logic [TIME_W-1:0]          mem [TASK_SLOTS];
   logic [TIME_W-1:0]          mem_q;
   logic                       mem_we;
   logic [SLOT_W-1:0]          mem_raddr;

   logic                       accept;
   logic                       in_range;
   logic [SLOT_W-1:0]          slot;
   logic [TIME_W+1:0]          three_sum;
   logic                       issue_done;
   logic [TIME_W-1:0]          ls;
   logic                       ls_never;
   logic [TIME_W-1:0]          gap;
   logic                       relevant;
   logic [MASK_W-1:0]          pbit;
   logic                       go;
   logic [TIME_W-1:0]          fin_gap;
   logic                       fin_fed;
   logic [TIME_W-1:0]          fin_remain;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign in_range  = (int'(req_data.task_id) < TASK_SLOTS);
   assign slot      = SLOT_W'(req_data.task_id);
   assign three_sum = {2'b00, silence_ff} + {1'b0, silence_ff, 1'b0};

   assign mem_we = accept && in_range &&
                   ((req_data.opcode == OP_REGISTER && req_data.handle_present && !reg_ff[slot]) ||
                    (req_data.opcode == OP_HEARTBEAT && reg_ff[slot]));

   assign issue_done = (issue_cnt_ff == CNT_W'(TASK_SLOTS));
   assign mem_raddr  = issue_cnt_ff[SLOT_W-1:0];

   assign ls       = valid_ff[proc_idx_ff] ? mem_q : '0;
   assign ls_never = (ls == '0);
   assign gap      = (now_ff >= ls) ? (now_ff - ls) : '0;
   assign relevant = reg_ff[proc_idx_ff] && slot_required(required_ff, proc_idx_ff);
   assign pbit     = slot_bit(proc_idx_ff);

   assign go         = armed_ff || (never_ff == '0) || warm_ff;
   assign fin_gap    = (never_ff != '0) ? silence_p1_ff : maxgap_ff;
   assign fin_fed    = (fin_gap <= silence_ff);
   assign fin_remain = silence_ff - fin_gap;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      rsp_in        = '0;
      rsp_in.status = STAT_DONE;
      rsp_in.armed  = armed_ff;
      rsp_valid_in  = 1'b0;
      if (accept && req_data.opcode != OP_CHECK) begin
         rsp_valid_in = 1'b1;
         if ((req_data.opcode == OP_REGISTER && !in_range) ||
             (req_data.opcode == OP_HEARTBEAT && (!in_range || !reg_ff[slot]))) begin
            rsp_in.status = STAT_IGNORED;
         end
      end else if (state_ff == ST_FINISH) begin
         rsp_valid_in       = 1'b1;
         rsp_in.warmup_done = warm_ff;
         if (!go) begin
            rsp_in.status       = STAT_WAITING;
            rsp_in.waiting_mask = waitm_ff;
         end else begin
            rsp_in.armed      = 1'b1;
            rsp_in.just_armed = !armed_ff;
            rsp_in.max_gap_ms = fin_gap;
            if (fin_fed) begin
               rsp_in.status       = STAT_FED;
               rsp_in.feed         = 1'b1;
               rsp_in.remaining_ms = fin_remain;
               rsp_in.warn_mask    = warn_ff;
            end else begin
               rsp_in.status       = STAT_STALE;
               rsp_in.overdue_mask = stale_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[slot] <= req_data.time_ms;
      end
      mem_q <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         silence_ff   <= SILENCE_RST;
         warmup_ff    <= WARMUP_RST;
         required_ff  <= REQUIRED_RST;
         armed_ff     <= 1'b0;
         start_ff     <= '0;
         reg_ff       <= '0;
         valid_ff     <= '0;
         issue_cnt_ff <= '0;
         proc_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_SILENCE:  silence_ff  <= csr_wdata[TIME_W-1:0];
               CSR_WARMUP:   warmup_ff   <= csr_wdata[TIME_W-1:0];
               CSR_REQUIRED: required_ff <= csr_wdata[MASK_W-1:0];
               default: ;
            endcase
         end
         if (mem_we) begin
            valid_ff[slot] <= 1'b1;
         end
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  now_ff        <= req_data.time_ms;
                  elapsed_ff    <= req_data.time_ms - start_ff;
                  silence_p1_ff <= (silence_ff == TIME_MAX) ? TIME_MAX : silence_ff + 1'b1;
                  three_q_ff    <= three_sum[TIME_W+1:2];
                  case (req_data.opcode)
                     OP_START: begin
                        start_ff <= req_data.time_ms;
                     end
                     OP_REGISTER: begin
                        if (in_range) begin
                           reg_ff[slot] <= req_data.handle_present;
                        end
                     end
                     OP_CHECK: begin
                        state_ff     <= ST_SCAN;
                        issue_cnt_ff <= '0;
                        proc_vld_ff  <= 1'b0;
                        maxgap_ff    <= '0;
                        never_ff     <= '0;
                        waitm_ff     <= '0;
                        warn_ff      <= '0;
                        stale_ff     <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            ST_SCAN: begin
               warm_ff <= (elapsed_ff >= warmup_ff);
               if (!issue_done) begin
                  issue_cnt_ff <= issue_cnt_ff + 1'b1;
                  proc_vld_ff  <= 1'b1;
                  proc_idx_ff  <= issue_cnt_ff[SLOT_W-1:0];
               end else begin
                  proc_vld_ff <= 1'b0;
               end
               if (proc_vld_ff) begin
                  if (ls_never && slot_required(required_ff, proc_idx_ff)) begin
                     waitm_ff <= waitm_ff | pbit;
                  end
                  if (relevant) begin
                     if (ls_never) begin
                        never_ff <= never_ff | pbit;
                        warn_ff  <= warn_ff | pbit;
                        stale_ff <= stale_ff | pbit;
                     end else begin
                        if (gap > maxgap_ff) begin
                           maxgap_ff <= gap;
                        end
                        if (gap >= three_q_ff) begin
                           warn_ff <= warn_ff | pbit;
                        end
                        if (gap > silence_ff) begin
                           stale_ff <= stale_ff | pbit;
                        end
                     end
                  end
                  if (issue_done) begin
                     state_ff <= ST_FINISH;
                  end
               end
            end
            ST_FINISH: begin
               if (go) begin
                  armed_ff <= 1'b1;
               end
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `THS_ASSERT_SAME(a_fed_feeds, clock, reset, rsp_valid_ff && rsp_ff.status == STAT_FED, rsp_ff.feed && rsp_ff.armed)
   `THS_ASSERT_SAME(a_arm_decides, clock, reset, rsp_valid_ff && rsp_ff.just_armed, rsp_ff.status == STAT_FED || rsp_ff.status == STAT_STALE)
   `THS_ASSERT_SAME(a_no_write_in_scan, clock, reset, state_ff != ST_IDLE, !mem_we)
   `THS_ASSERT_NEXT(a_armed_holds, clock, reset, armed_ff, armed_ff)
   `THS_ASSERT_NEXT(a_check_busy, clock, reset, accept && req_data.opcode == OP_CHECK, busy && !rsp_valid_ff)
   `THS_ASSERT_NEXT(a_quick_item, clock, reset, accept && req_data.opcode != OP_CHECK, rsp_valid_ff && !busy)

endmodule
